// ----- src/xeu_pkg.sv -----
// Shared types and character codes for the XML entity unescaper.
// Used by xeu_decode and xml_entity_unescape; depends on nothing else.
package xeu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_end;
        logic       string_end;
    } out_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } dec_t;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;

    localparam logic [2:0] SKIP_SHORT = 3'd2;
    localparam logic [2:0] SKIP_APOS  = 3'd3;
    localparam logic [2:0] SKIP_QUOT  = 3'd4;

endpackage

// ----- src/xml_entity_unescape.sv -----
// Top level of the XML entity unescaper: input register, decoder and result buffer.
// Depends on xeu_pkg and xeu_decode.
//
// Usage: escaped bytes enter on the in_valid/in_ready channel as in_data, with
// in_last set on the final byte of each string. Decoded bytes leave on the
// out_valid/out_ready channel as out_data. Each input transfer gives zero, one
// or two result transfers; a final byte that decodes to nothing gives a marker
// with byte_present low. run_end flags the last result of an input transfer and
// string_end the last result of a string.
// A result passes through the input register and then the result buffer before
// it is offered on the out_valid/out_ready channel.
// Throughput: one input transfer per cycle while the receiver keeps up; an
// input that yields two results waits in the input register while the buffer
// still holds a result after this cycle's output transfer.
// One input byte can wait in the input register while results wait to be taken.
// Reset clears the input register, the result buffer and the decoder state to
// idle with no entity pending. When out_ready is low, results stay put and the
// input side stops accepting once the input register is full.
module xml_entity_unescape (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  xeu_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output xeu_pkg::out_t out_data
);
    import xeu_pkg::*;

    in_t        item_reg;
    logic       item_valid_reg;
    logic       item_valid_next;
    out_t       q0_reg;
    out_t       q0_next;
    out_t       q1_reg;
    out_t       q1_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] base;
    logic       pop;
    logic       move;
    dec_t       dec;

    xeu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_reg),
        .advance (move),
        .result  (dec)
    );

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q0_reg;
    assign pop       = out_valid && out_ready;
    assign base      = cnt_reg - {1'b0, pop};
    assign move      = item_valid_reg &&
                       ((dec.count == 2'd0) || (base == 2'd0) ||
                        ((base == 2'd1) && (dec.count == 2'd1)));
    assign in_ready  = !item_valid_reg || move;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (move)
        begin
            item_valid_next = 1'b0;
        end

        q0_next  = pop ? q1_reg : q0_reg;
        q1_next  = q1_reg;
        cnt_next = base;
        if (move && dec.count != 2'd0)
        begin
            if (base == 2'd0)
            begin
                q0_next = dec.first;
            end
            else
            begin
                q1_next = dec.first;
            end
            if (dec.count == 2'd2)
            begin
                q1_next = dec.second;
            end
            cnt_next = base + dec.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

// ----- src/xeu_decode.sv -----
// Entity decoder: holds the match state and turns one byte into up to two results.
// Depends on xeu_pkg.
module xeu_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  xeu_pkg::in_t  item,
    input  logic          advance,
    output xeu_pkg::dec_t result
);
    import xeu_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AMP,
        MODE_AMP_A,
        MODE_SKIP
    } mode_t;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [2:0] skip_reg;
    logic [2:0] skip_next;
    logic [2:0] skip_dec;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [1:0] cnt;
    logic [7:0] b;

    always_comb
    begin
        b         = item.in_byte;
        mode_next = mode_reg;
        skip_next = skip_reg;
        skip_dec  = 3'd0;
        e0        = 8'd0;
        e1        = 8'd0;
        cnt       = 2'd0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (b == CH_AMP)
                begin
                    mode_next = MODE_AMP;
                end
                else
                begin
                    e0  = b;
                    cnt = 2'd1;
                end
            end
            MODE_AMP:
            begin
                mode_next = MODE_IDLE;
                if (b == CH_L || b == CH_G || b == CH_Q)
                begin
                    cnt       = 2'd1;
                    mode_next = MODE_SKIP;
                    if (b == CH_L)
                    begin
                        e0        = CH_LT;
                        skip_next = SKIP_SHORT;
                    end
                    else if (b == CH_G)
                    begin
                        e0        = CH_GT;
                        skip_next = SKIP_SHORT;
                    end
                    else
                    begin
                        e0        = CH_QUOT;
                        skip_next = SKIP_QUOT;
                    end
                end
                else if (b == CH_A)
                begin
                    mode_next = MODE_AMP_A;
                end
                else if (b == CH_AMP)
                begin
                    mode_next = MODE_AMP;
                end
                else
                begin
                    e0  = b;
                    cnt = 2'd1;
                end
            end
            MODE_AMP_A:
            begin
                mode_next = MODE_IDLE;
                if (b == CH_M)
                begin
                    e0        = CH_AMP;
                    cnt       = 2'd1;
                    mode_next = MODE_SKIP;
                    skip_next = SKIP_SHORT;
                end
                else if (b == CH_P)
                begin
                    e0        = CH_APOS;
                    cnt       = 2'd1;
                    mode_next = MODE_SKIP;
                    skip_next = SKIP_APOS;
                end
                else
                begin
                    e0  = CH_A;
                    cnt = 2'd1;
                    if (b == CH_AMP)
                    begin
                        mode_next = MODE_AMP;
                    end
                    else
                    begin
                        e1  = b;
                        cnt = 2'd2;
                    end
                end
            end
            MODE_SKIP:
            begin
                if (skip_reg != 3'd0)
                begin
                    skip_dec = skip_reg - 3'd1;
                end
                skip_next = skip_dec;
                if (skip_dec == 3'd0)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (item.in_last)
        begin
            if (mode_next == MODE_AMP_A)
            begin
                e0  = CH_A;
                cnt = 2'd1;
            end
            mode_next = MODE_IDLE;
            skip_next = 3'd0;
        end

        result.count         = cnt;
        result.first         = '0;
        result.second        = '0;
        if (cnt == 2'd0)
        begin
            if (item.in_last)
            begin
                result.count            = 2'd1;
                result.first.run_end    = 1'b1;
                result.first.string_end = 1'b1;
            end
        end
        else
        begin
            result.first.out_byte      = e0;
            result.first.byte_present  = 1'b1;
            result.first.run_end       = (cnt == 2'd1);
            result.first.string_end    = (cnt == 2'd1) && item.in_last;
            result.second.out_byte     = e1;
            result.second.byte_present = 1'b1;
            result.second.run_end      = 1'b1;
            result.second.string_end   = item.in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            skip_reg <= 3'd0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
        end
    end

endmodule
